// File: rtl/core/perimeter_matched_filter_detector_top_macros.svh
// Assertion macros for the perimeter matched filter detector.
// Expects clk and rst_n in the scope of each use.
`ifndef PERIMETER_MATCHED_FILTER_DETECTOR_TOP_MACROS_SVH
`define PERIMETER_MATCHED_FILTER_DETECTOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PMFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pmfd_pkg.sv
// Shared types, constants and code tables of the perimeter matched filter detector.
// No dependencies.
package pmfd_pkg;

  localparam int TAPS_DEF        = 24;
  localparam int CAPTURE_MAX_DEF = 255;
  localparam int CHANNELS_DEF    = 2;

  localparam int SAMPLE_W = 8;
  localparam int MAG_W    = 13;
  localparam int QUAL_W   = 16;
  localparam int SMAG_W   = 12;
  localparam int ACC_W    = 28;
  localparam int MS_W     = 17;
  localparam int SIDE_W   = 3;
  localparam int THR_W    = 12;
  localparam int TOMS_W   = 16;
  localparam int ALPHA_W  = 10;
  localparam int SUM_W_DEF = 14;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int CODE_LEN   = 24;
  localparam int CODE_IDX_W = 5;

  // Divider: numerator below 2^14, shifted left by the 8 fraction bits.
  localparam int NUM_W      = 14;
  localparam int DVD_W      = NUM_W + 8;
  localparam int DIV_CNT_W  = $clog2(DVD_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_USE_DIFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_THR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_MS    = 2'd3;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic signed [MAG_W-1:0]  MAG_MAX  = 13'sd4095;
  localparam logic signed [MAG_W-1:0]  MAG_MIN  = -13'sd4096;
  localparam logic signed [SIDE_W-1:0] SIDE_MAX = 3'sd3;
  localparam logic signed [SIDE_W-1:0] SIDE_MIN = -3'sd3;
  localparam logic [ALPHA_W-1:0]       ALPHA_Q16 = 10'd655;
  localparam logic [ACC_W-1:0]         ACC_MAX  = {ACC_W{1'b1}};
  localparam logic [MS_W-1:0]          MS_MAX   = {MS_W{1'b1}};
  localparam logic [QUAL_W-1:0]        QUAL_MAX = {QUAL_W{1'b1}};

  localparam logic [THR_W-1:0]  TO_THR_RST = 12'd300;
  localparam logic [TOMS_W-1:0] TO_MS_RST  = 16'd8000;

  typedef logic signed [1:0] coef_t;

  localparam coef_t CODE_NORM [CODE_LEN] = '{
    2'sb01, 2'sb01, 2'sb11, 2'sb11, 2'sb01, 2'sb11, 2'sb01, 2'sb11,
    2'sb11, 2'sb01, 2'sb11, 2'sb01, 2'sb01, 2'sb11, 2'sb11, 2'sb01,
    2'sb11, 2'sb11, 2'sb01, 2'sb11, 2'sb11, 2'sb01, 2'sb01, 2'sb11};

  localparam coef_t CODE_DIFF [CODE_LEN] = '{
    2'sb01, 2'sb00, 2'sb11, 2'sb00, 2'sb01, 2'sb11, 2'sb01, 2'sb11,
    2'sb00, 2'sb01, 2'sb11, 2'sb01, 2'sb00, 2'sb11, 2'sb00, 2'sb01,
    2'sb11, 2'sb00, 2'sb01, 2'sb11, 2'sb00, 2'sb01, 2'sb00, 2'sb11};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV
  } pmfd_state_t;

  function automatic coef_t code_coef(input logic use_diff, input logic [CODE_IDX_W-1:0] idx);
    code_coef = use_diff ? CODE_DIFF[idx] : CODE_NORM[idx];
  endfunction

endpackage

// File: rtl/core/pmfd_if.sv
// Handshake interfaces for the sample input and result output channels.
// Depends on pmfd_pkg.
interface pmfd_in_if import pmfd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic                       channel;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, command, channel, sample, last, input ready);
  modport sink (input valid, command, channel, sample, last, output ready);
endinterface

interface pmfd_out_if import pmfd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    out_channel;
  logic signed [MAG_W-1:0] magnitude;
  logic [QUAL_W-1:0]       quality;
  logic [SMAG_W-1:0]       smooth_magnitude;
  logic                    inside_res;
  logic                    timed_out;

  modport source (output valid, out_channel, magnitude, quality, smooth_magnitude,
                  inside_res, timed_out, input ready);
  modport sink (input valid, out_channel, magnitude, quality, smooth_magnitude,
                inside_res, timed_out, output ready);
endinterface

// File: rtl/core/pmfd_cell.sv
// One tap of the transposed correlator chain: adds its code term to the
// partial sum handed over by its neighbor. Depends on pmfd_pkg.
module pmfd_cell import pmfd_pkg::*; #(
  parameter int SUM_W = SUM_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift_en,
  input  logic                       clear,
  input  logic signed [SAMPLE_W-1:0] x,
  input  coef_t                      coef,
  input  logic signed [SUM_W-1:0]    p_in,
  output logic signed [SUM_W-1:0]    p_out
);

  logic signed [SUM_W-1:0] p_r;
  logic signed [SUM_W-1:0] p_nxt;
  logic signed [SUM_W-1:0] term;

  always_comb begin
    case (coef)
      2'sb01:  term = SUM_W'(x);
      2'sb11:  term = -SUM_W'(x);
      default: term = '0;
    endcase
    p_nxt = p_in + term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      p_r <= '0;
    end else if (shift_en) begin
      p_r <= p_nxt;
    end
  end

  assign p_out = p_r;

endmodule

// File: rtl/core/pmfd_div.sv
// Restoring divider, one quotient bit per cycle, for the Q8.8 peak ratio.
// Saturates on overflow and on a zero divisor. Depends on pmfd_pkg.
module pmfd_div import pmfd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [NUM_W-1:0]  den,
  output logic              done,
  output logic [QUAL_W-1:0] quot
);

  logic [DVD_W-1:0]     quo_r;
  logic [NUM_W-1:0]     rem_r;
  logic [NUM_W-1:0]     den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [NUM_W:0]       rem_sh;
  logic [NUM_W:0]       rem_sub;
  logic                 q_bit;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    q_bit   = (rem_sh >= {1'b0, den_r});
    rem_sub = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && cnt_r == DIV_CNT_W'(1)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= {num, 8'd0};
      rem_r <= '0;
      den_r <= den;
      cnt_r <= DIV_CNT_W'(DVD_W);
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], q_bit};
      rem_r <= q_bit ? rem_sub[NUM_W-1:0] : rem_sh[NUM_W-1:0];
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  assign done = done_r;
  assign quot = (den_r == '0 || |quo_r[DVD_W-1:QUAL_W]) ? QUAL_MAX : quo_r[QUAL_W-1:0];

endmodule

// File: rtl/core/perimeter_matched_filter_detector_top.sv
// Perimeter matched filter detector. Sample and tick items are taken one per
// cycle; a sample with the last flag set ends the capture and keeps the input
// closed while the divider operands are latched and the 22-step ratio divider
// runs; the result is written once the ratio is ready. The input stays
// closed longer while an earlier result still waits in the output register.
// Correlation runs in two chains of TAPS cells holding partial window sums, one
// chain per code, so the code selected when a window is formed covers all taps.
// Depends on pmfd_pkg, pmfd_if, pmfd_cell, pmfd_div and the macro header.
`include "perimeter_matched_filter_detector_top_macros.svh"

module perimeter_matched_filter_detector_top import pmfd_pkg::*; #(
  parameter int TAPS        = TAPS_DEF,
  parameter int CAPTURE_MAX = CAPTURE_MAX_DEF,
  parameter int CHANNELS    = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pmfd_in_if.sink               in_ch,
  pmfd_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SUM_W  = (9 + $clog2(TAPS) > MAG_W) ? 9 + $clog2(TAPS) : MAG_W;
  localparam int SEEN_W = $clog2(CAPTURE_MAX + 1);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PA_W   = ACC_W + ALPHA_W;
  localparam int PM_W   = MAG_W + ALPHA_W;

  logic              use_diff_r;
  logic              swap_r;
  logic [THR_W-1:0]  to_thr_r;
  logic [TOMS_W-1:0] to_ms_r;

  pmfd_state_t state_r, state_nxt;
  logic        in_ready;
  logic        div_start;
  logic        finish;

  logic in_fire, smp_fire, tick_fire, shift_en, cap_end;

  logic signed [SUM_W-1:0] psum_n [TAPS+1];
  logic signed [SUM_W-1:0] psum_d [TAPS+1];
  logic signed [SUM_W-1:0] win;
  logic signed [MAG_W-1:0] win_clamp;
  logic [SEEN_W-1:0]       seen_r;
  logic                    win_ok;

  logic signed [MAG_W-1:0] peak_high_r, peak_low_r;

  logic [CH_W-1:0]         ch_in, ch_r;
  logic                    chan_field_r;

  logic signed [NUM_W-1:0] ph_x, nl_x, mag_x, neg_x;
  logic                    dom_high;
  logic [NUM_W-1:0]        div_num, div_den;
  logic signed [MAG_W-1:0] mag_fin;
  logic signed [MAG_W-1:0] mag_r;
  logic [MAG_W-1:0]        amag_r;

  logic                    div_done;
  logic [QUAL_W-1:0]       div_quot;

  logic [ACC_W-1:0]         acc_r  [CHANNELS];
  logic signed [SIDE_W-1:0] side_r [CHANNELS];
  logic [MS_W-1:0]          ms_r   [CHANNELS];

  logic [PA_W-1:0]          prod_a_r;
  logic [PM_W-1:0]          prod_m_r;
  logic [ACC_W-1:0]         acc_sel;
  logic [ACC_W+1:0]         acc_sum;
  logic [ACC_W-1:0]         acc_new;
  logic [SMAG_W-1:0]        smag;
  logic signed [SIDE_W-1:0] side_sel, side_nxt;
  logic [MS_W-1:0]          ms_new;
  logic                     mag_pos;

  logic                    out_valid_r;
  logic                    out_channel_r;
  logic signed [MAG_W-1:0] out_mag_r;
  logic [QUAL_W-1:0]       out_qual_r;
  logic [SMAG_W-1:0]       out_smag_r;
  logic                    out_inside_r;
  logic                    out_to_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_diff_r <= 1'b0;
      swap_r     <= 1'b0;
      to_thr_r   <= TO_THR_RST;
      to_ms_r    <= TO_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_USE_DIFF: use_diff_r <= cfg_wdata[0];
        CFG_SWAP:     swap_r     <= cfg_wdata[0];
        CFG_TO_THR:   to_thr_r   <= cfg_wdata[THR_W-1:0];
        CFG_TO_MS:    to_ms_r    <= cfg_wdata[TOMS_W-1:0];
        default:      ;
      endcase
    end
  end

  // Control state machine.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    div_start = 1'b0;
    finish    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid && in_ch.command == CMD_SAMPLE && in_ch.last) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done && (!out_valid_r || out_ch.ready)) begin
          finish    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;
  assign smp_fire    = in_fire && in_ch.command == CMD_SAMPLE;
  assign tick_fire   = in_fire && in_ch.command == CMD_TICK;
  assign shift_en    = smp_fire && !in_ch.last;
  assign cap_end     = smp_fire && in_ch.last;

  // Correlator chains, one per code; cell 0 of each holds its full window sum.
  assign psum_n[TAPS] = '0;
  assign psum_d[TAPS] = '0;

  for (genvar j = 0; j < TAPS; j++) begin : g_cell
    localparam int CI = (TAPS - 1 - j) % CODE_LEN;
    pmfd_cell #(.SUM_W(SUM_W)) u_cell_n (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .clear    (cap_end),
      .x        (in_ch.sample),
      .coef     (code_coef(1'b0, CODE_IDX_W'(CI))),
      .p_in     (psum_n[j+1]),
      .p_out    (psum_n[j])
    );
    pmfd_cell #(.SUM_W(SUM_W)) u_cell_d (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .clear    (cap_end),
      .x        (in_ch.sample),
      .coef     (code_coef(1'b1, CODE_IDX_W'(CI))),
      .p_in     (psum_d[j+1]),
      .p_out    (psum_d[j])
    );
  end

  assign win    = use_diff_r ? psum_d[0] : psum_n[0];
  assign win_ok = (int'(seen_r) >= TAPS);

  always_comb begin
    if (win > SUM_W'(MAG_MAX)) begin
      win_clamp = MAG_MAX;
    end else if (win < SUM_W'(MAG_MIN)) begin
      win_clamp = MAG_MIN;
    end else begin
      win_clamp = win[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      peak_high_r <= '0;
      peak_low_r  <= '0;
    end else begin
      if (cap_end) begin
        seen_r <= '0;
      end else if (shift_en && int'(seen_r) < CAPTURE_MAX) begin
        seen_r <= seen_r + SEEN_W'(1);
      end
      if (finish) begin
        peak_high_r <= '0;
        peak_low_r  <= '0;
      end else if (smp_fire && win_ok) begin
        if (win > SUM_W'(peak_high_r)) begin
          peak_high_r <= win_clamp;
        end
        if (win < SUM_W'(peak_low_r)) begin
          peak_low_r <= win_clamp;
        end
      end
    end
  end

  always_comb begin
    if (int'(in_ch.channel) < CHANNELS) begin
      ch_in = CH_W'(in_ch.channel);
    end else begin
      ch_in = CH_W'(CHANNELS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (cap_end) begin
      ch_r         <= ch_in;
      chan_field_r <= in_ch.channel;
    end
  end

  // Dominant peak and divider operands, taken once the peaks are final.
  always_comb begin
    ph_x     = NUM_W'(peak_high_r);
    nl_x     = -NUM_W'(peak_low_r);
    dom_high = (ph_x > nl_x);
    div_num  = dom_high ? ph_x : nl_x;
    div_den  = dom_high ? nl_x : ph_x;
    mag_x    = dom_high ? NUM_W'(peak_high_r) : NUM_W'(peak_low_r);
    neg_x    = -mag_x;
    if (!swap_r) begin
      mag_fin = mag_x[MAG_W-1:0];
    end else if (neg_x > NUM_W'(MAG_MAX)) begin
      mag_fin = MAG_MAX;
    end else begin
      mag_fin = neg_x[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      mag_r  <= mag_fin;
      amag_r <= mag_fin[MAG_W-1] ? MAG_W'(-NUM_W'(mag_fin)) : mag_fin;
    end
  end

  pmfd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Smoothing products, settled long before the divider finishes.
  assign acc_sel  = acc_r[ch_r];
  assign side_sel = side_r[ch_r];

  always_ff @(posedge clk) begin
    prod_a_r <= PA_W'(acc_sel) * PA_W'(ALPHA_Q16);
    prod_m_r <= PM_W'(amag_r) * PM_W'(ALPHA_Q16);
  end

  always_comb begin
    acc_sum = (ACC_W+2)'(acc_sel) - (ACC_W+2)'(prod_a_r[PA_W-1:16])
            + (ACC_W+2)'(prod_m_r);
    acc_new = (|acc_sum[ACC_W+1:ACC_W]) ? ACC_MAX : acc_sum[ACC_W-1:0];
    smag    = acc_new[ACC_W-1:16];
    mag_pos = !mag_r[MAG_W-1] && (mag_r != '0);
    if (mag_pos) begin
      side_nxt = (side_sel < SIDE_MAX) ? side_sel + SIDE_W'(1) : side_sel;
    end else begin
      side_nxt = (side_sel > SIDE_MIN) ? side_sel - SIDE_W'(1) : side_sel;
    end
    ms_new = side_nxt[SIDE_W-1] ? '0 : ms_r[ch_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CHANNELS; k++) begin
        acc_r[k]  <= '0;
        side_r[k] <= '0;
        ms_r[k]   <= '0;
      end
    end else begin
      for (int k = 0; k < CHANNELS; k++) begin
        if (tick_fire) begin
          if (ms_r[k] != MS_MAX) begin
            ms_r[k] <= ms_r[k] + MS_W'(1);
          end
        end else if (finish && ch_r == CH_W'(k)) begin
          acc_r[k]  <= acc_new;
          side_r[k] <= side_nxt;
          ms_r[k]   <= ms_new;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_channel_r <= chan_field_r;
      out_mag_r     <= mag_r;
      out_qual_r    <= div_quot;
      out_smag_r    <= smag;
      out_inside_r  <= side_nxt[SIDE_W-1];
      out_to_r      <= (smag < to_thr_r) || (ms_new > {1'b0, to_ms_r});
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.out_channel      = out_channel_r;
  assign out_ch.magnitude        = out_mag_r;
  assign out_ch.quality          = out_qual_r;
  assign out_ch.smooth_magnitude = out_smag_r;
  assign out_ch.inside_res       = out_inside_r;
  assign out_ch.timed_out        = out_to_r;

  `PMFD_ASSERT_NOW(a_busy_blocks_input, state_r != ST_IDLE, !in_ch.ready, "Input transfer during capture evaluation.")
  `PMFD_ASSERT_NOW(a_peak_signs, 1'b1, !peak_high_r[MAG_W-1] && (peak_low_r[MAG_W-1] || peak_low_r == '0), "Peak registers hold the wrong sign.")
  `PMFD_ASSERT_NOW(a_finish_after_div, finish, div_done, "Result formed before the ratio is ready.")
  `PMFD_ASSERT_NEXT(a_finish_loads_out, finish, out_valid_r && state_r == ST_IDLE && peak_high_r == '0, "Capture end did not load the result.")

endmodule
